### src/hmpb_pkg.sv
`default_nettype none
package hmpb_pkg;

    localparam int MAX_BASE_WIDTH = 2048;
    localparam int MAX_LEVELS     = 12;

    localparam int SIZE_W      = $clog2(MAX_BASE_WIDTH + 1);
    localparam int CNT_W       = $clog2(MAX_BASE_WIDTH);
    localparam int NUM_LVL     = MAX_LEVELS - 1;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int STORE_DEPTH = MAX_BASE_WIDTH - 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int DEPTH_W = 32;
    localparam int LIDX_W  = 4;
    localparam int POS_W   = 10;
    localparam int CIDX_W  = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CIDX_W-1:0] REG_BASE_WIDTH  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_BASE_HEIGHT = CIDX_W'(1);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               trivial;   // level zero is 1x1: nothing to build
    } t_item;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              restart;
    } t_geom;

    // IEEE single c < a; NaN or +0/-0 pairs compare false
    function automatic logic flt_less(input logic [31:0] c, input logic [31:0] a);
        logic nan_c;
        logic nan_a;
        logic zeros;
        logic res;
        nan_c = (&c[30:23]) && (|c[22:0]);
        nan_a = (&a[30:23]) && (|a[22:0]);
        zeros = (c[30:0] == 31'd0) && (a[30:0] == 31'd0);
        if (nan_c || nan_a || zeros) begin
            res = 1'b0;
        end else if (c[31] != a[31]) begin
            res = c[31];
        end else if (!c[31]) begin
            res = c[30:0] < a[30:0];
        end else begin
            res = c[30:0] > a[30:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] fold_min(input logic [31:0] kept, input logic [31:0] cand);
        return flt_less(cand, kept) ? cand : kept;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) r = SIZE_W'(1);
        if (v > SIZE_W'(MAX_BASE_WIDTH)) r = SIZE_W'(MAX_BASE_WIDTH);
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] half_up(input logic [SIZE_W-1:0] v);
        return (v >> 1) + SIZE_W'(v[0]);
    endfunction

endpackage
`default_nettype wire

### src/hiz_min_pyramid_build_unit.sv
`default_nettype none
// channel   handshake                  payload
// cfg       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data (base_width, base_height)
// in        i_in_valid / o_in_stall    i_depth_bits
// out       o_out_valid / i_out_stall  o_level_index, o_pos_x, o_pos_y, o_min_depth, o_run_last
//
// Each input word passes through the front queue, then the back end visits each level
// with a row store read, then a fold; the registered read of the row store is why each
// level step has its own read state.
// Synchronous active-low reset; the row store is not cleared. A stalled output holds the
// back end only when it has a finished pixel to hand over; the 4-word queue keeps taking
// input meanwhile until it is full.
module hiz_min_pyramid_build_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hmpb_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [hmpb_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [hmpb_pkg::DEPTH_W-1:0]   i_depth_bits,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [hmpb_pkg::LIDX_W-1:0]         o_level_index,
    output logic [hmpb_pkg::POS_W-1:0]          o_pos_x,
    output logic [hmpb_pkg::POS_W-1:0]          o_pos_y,
    output logic [hmpb_pkg::DEPTH_W-1:0]        o_min_depth,
    output logic                                o_run_last
);
    import hmpb_pkg::*;

    t_geom              geom;
    t_item              q_item;
    logic               q_valid, q_pop;
    logic [ADDR_W-1:0]  ram_raddr, ram_waddr;
    logic [DEPTH_W-1:0] ram_rdata, ram_wdata;
    logic               ram_we;

    // front: size registers, frame restart, word queue
    hmpb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_depth_bits (i_depth_bits),
        .o_geom       (geom),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    // back: walks the levels of one word, folding and emitting
    hmpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_level_index (o_level_index),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_min_depth   (o_min_depth),
        .o_run_last    (o_run_last)
    );

    // top-row pair minima for all levels, packed by level offset
    hmpb_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (STORE_DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule
`default_nettype wire

### src/hmpb_ram.sv
`default_nettype none
module hmpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2047
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/hmpb_front.sv
`default_nettype none
module hmpb_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hmpb_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [hmpb_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [hmpb_pkg::DEPTH_W-1:0]   i_depth_bits,
    output hmpb_pkg::t_geom                     o_geom,
    output logic                                o_q_valid,
    output hmpb_pkg::t_item                     o_q_item,
    input  wire logic                           i_q_pop
);
    import hmpb_pkg::*;

    logic [SIZE_W-1:0] r_width, r_height;
    logic              r_restart;
    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head, r_tail;
    logic [QPTR_W:0]   r_count;
    logic              push, pop, cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_in_stall  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_q_valid   = (r_count != '0);
    assign pop         = i_q_pop && o_q_valid;
    assign o_q_item    = r_q[r_head];

    assign o_geom.width   = r_width;
    assign o_geom.height  = r_height;
    assign o_geom.restart = r_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= SIZE_W'(MAX_BASE_WIDTH);
            r_height  <= SIZE_W'(MAX_BASE_WIDTH);
            r_restart <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            r_restart <= 1'b0;
            if (cfg_we && i_cfg_index == REG_BASE_WIDTH) begin
                r_width   <= clamp_size(i_cfg_data);
                r_restart <= 1'b1;
            end else if (cfg_we && i_cfg_index == REG_BASE_HEIGHT) begin
                r_height  <= clamp_size(i_cfg_data);
                r_restart <= 1'b1;
            end
            if (push) r_tail <= r_tail + QPTR_W'(1);
            if (pop)  r_head <= r_head + QPTR_W'(1);
            if (push && !pop)      r_count <= r_count + (QPTR_W+1)'(1);
            else if (!push && pop) r_count <= r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_tail].depth   <= i_depth_bits;
            r_q[r_tail].trivial <= (r_width == SIZE_W'(1)) && (r_height == SIZE_W'(1));
        end
    end
endmodule
`default_nettype wire

### src/hmpb_back.sv
`default_nettype none
module hmpb_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire hmpb_pkg::t_geom                i_geom,
    input  wire logic                           i_q_valid,
    input  wire hmpb_pkg::t_item                i_q_item,
    output logic                                o_q_pop,
    output logic [hmpb_pkg::ADDR_W-1:0]         o_ram_raddr,
    input  wire logic [hmpb_pkg::DEPTH_W-1:0]   i_ram_rdata,
    output logic                                o_ram_we,
    output logic [hmpb_pkg::ADDR_W-1:0]         o_ram_waddr,
    output logic [hmpb_pkg::DEPTH_W-1:0]        o_ram_wdata,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [hmpb_pkg::LIDX_W-1:0]         o_level_index,
    output logic [hmpb_pkg::POS_W-1:0]          o_pos_x,
    output logic [hmpb_pkg::POS_W-1:0]          o_pos_y,
    output logic [hmpb_pkg::DEPTH_W-1:0]        o_min_depth,
    output logic                                o_run_last
);
    import hmpb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EX   = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [LVL_W-1:0]   r_lv, n_lv;
    logic [SIZE_W-1:0]  r_w, n_w, r_h, n_h;
    logic [ADDR_W-1:0]  r_off, n_off;
    logic [DEPTH_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]   r_col [NUM_LVL];
    logic [CNT_W-1:0]   r_row [NUM_LVL];
    logic [DEPTH_W-1:0] r_pair [NUM_LVL];

    // result of the previous level, held until we know if it ends the run
    logic               r_pend_v, n_pend_v;
    logic [LIDX_W-1:0]  r_pend_l, n_pend_l;
    logic [POS_W-1:0]   r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic [DEPTH_W-1:0] r_pend_d, n_pend_d;

    logic [CNT_W-1:0]   x, y, n_colv, n_rowv;
    logic [SIZE_W-1:0]  x1, y1, w_nx, h_nx;
    logic               has_right, has_bottom, done_cur, done_raw, go_next;
    logic               commit, pair_we, slot_free, out_load, out_last;
    logic [DEPTH_W-1:0] res, n_pairv;
    logic [ADDR_W-1:0]  idx;
    logic [LIDX_W-1:0]  out_l;
    logic [POS_W-1:0]   out_x, out_y;
    logic [DEPTH_W-1:0] out_d;

    assign x          = r_col[r_lv];
    assign y          = r_row[r_lv];
    assign x1         = SIZE_W'(x) + SIZE_W'(1);
    assign y1         = SIZE_W'(y) + SIZE_W'(1);
    assign has_right  = x1 < r_w;
    assign has_bottom = y1 < r_h;
    assign idx        = r_off + ADDR_W'(x >> 1);
    assign w_nx       = half_up(r_w);
    assign h_nx       = half_up(r_h);
    assign go_next    = !((w_nx == SIZE_W'(1)) && (h_nx == SIZE_W'(1)))
                        && ((LVL_W+1)'(r_lv) + (LVL_W+1)'(2) < (LVL_W+1)'(MAX_LEVELS));
    assign slot_free  = !o_out_valid || !i_out_stall;
    assign o_ram_raddr = idx;

    // emission and bookkeeping, known from position alone
    assign done_cur = y[0] ? (x[0] || !has_right)
                           : ((x[0] || !has_right) && !has_bottom);

    always_comb begin
        n_colv = '0;
        n_rowv = y;
        if (x1 >= r_w) n_rowv = (y1 >= r_h) ? '0 : CNT_W'(y1);
        else           n_colv = CNT_W'(x1);

        n_pairv  = r_val;
        pair_we  = 1'b0;
        res      = r_val;
        done_raw = 1'b0;
        if (!y[0]) begin
            if (!x[0]) begin
                pair_we  = 1'b1;
                done_raw = !has_right;
            end else begin
                res      = fold_min(r_pair[r_lv], r_val);
                done_raw = 1'b1;
            end
        end else begin
            if (!x[0]) begin
                res     = fold_min(i_ram_rdata, r_val);
                n_pairv = res;
                pair_we = has_right;
            end else begin
                res = fold_min(r_pair[r_lv], r_val);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_lv     = r_lv;
        n_w      = r_w;
        n_h      = r_h;
        n_off    = r_off;
        n_val    = r_val;
        n_pend_v = r_pend_v;
        n_pend_l = r_pend_l;
        n_pend_x = r_pend_x;
        n_pend_y = r_pend_y;
        n_pend_d = r_pend_d;
        o_q_pop  = 1'b0;
        commit   = 1'b0;
        out_load = 1'b0;
        out_last = 1'b0;
        out_l    = r_pend_l;
        out_x    = r_pend_x;
        out_y    = r_pend_y;
        out_d    = r_pend_d;
        o_ram_we    = 1'b0;
        o_ram_waddr = idx;
        o_ram_wdata = res;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (!i_q_item.trivial) begin
                        n_val   = i_q_item.depth;
                        n_lv    = '0;
                        n_w     = i_geom.width;
                        n_h     = i_geom.height;
                        n_off   = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (!r_pend_v) begin
                    n_state = S_EX;
                end else if (slot_free) begin
                    out_load = 1'b1;
                    out_last = !done_cur;
                    n_pend_v = 1'b0;
                    n_state  = S_EX;
                end
            end
            S_EX: begin
                if (done_cur && go_next) begin
                    commit   = 1'b1;
                    n_pend_v = 1'b1;
                    n_pend_l = LIDX_W'(r_lv) + LIDX_W'(1);
                    n_pend_x = POS_W'(x >> 1);
                    n_pend_y = POS_W'(y >> 1);
                    n_pend_d = res;
                    n_val    = res;
                    n_lv     = r_lv + LVL_W'(1);
                    n_w      = w_nx;
                    n_h      = h_nx;
                    n_off    = ADDR_W'(SIZE_W'(r_off) + w_nx);
                    n_state  = S_RD;
                end else if (done_cur) begin
                    if (slot_free) begin
                        commit   = 1'b1;
                        out_load = 1'b1;
                        out_last = 1'b1;
                        out_l    = LIDX_W'(r_lv) + LIDX_W'(1);
                        out_x    = POS_W'(x >> 1);
                        out_y    = POS_W'(y >> 1);
                        out_d    = res;
                        n_state  = S_IDLE;
                    end
                end else begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
                o_ram_we = commit && !y[0] && done_raw && has_bottom;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom.restart) begin
            r_state     <= S_IDLE;
            r_pend_v    <= 1'b0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LVL; i++) begin
                r_col[i]  <= '0;
                r_row[i]  <= '0;
                r_pair[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            if (out_load)         o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
            if (commit) begin
                r_col[r_lv] <= n_colv;
                r_row[r_lv] <= n_rowv;
                if (pair_we) r_pair[r_lv] <= n_pairv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv     <= n_lv;
        r_w      <= n_w;
        r_h      <= n_h;
        r_off    <= n_off;
        r_val    <= n_val;
        r_pend_l <= n_pend_l;
        r_pend_x <= n_pend_x;
        r_pend_y <= n_pend_y;
        r_pend_d <= n_pend_d;
        if (out_load) begin
            o_level_index <= out_l;
            o_pos_x       <= out_x;
            o_pos_y       <= out_y;
            o_min_depth   <= out_d;
            o_run_last    <= out_last;
        end
    end
endmodule
`default_nettype wire

### src/hmpb_checker.sv
`default_nettype none
module hmpb_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [hmpb_pkg::LIDX_W-1:0]    o_level_index,
    input  wire logic [hmpb_pkg::POS_W-1:0]     o_pos_x,
    input  wire logic [hmpb_pkg::POS_W-1:0]     o_pos_y,
    input  wire logic [hmpb_pkg::DEPTH_W-1:0]   o_min_depth,
    input  wire logic                           o_run_last
);
    import hmpb_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_min_depth)
            && $stable(o_level_index) && $stable(o_run_last)
            && $stable(o_pos_x) && $stable(o_pos_y))
        else $error("stalled word changed");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_level_index >= LIDX_W'(1)
            && o_level_index <= LIDX_W'(MAX_LEVELS - 1))
        else $error("level out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("word after reset");

    a_cascade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_run_last ##1 o_out_valid)
            |-> o_level_index == $past(o_level_index) + LIDX_W'(1))
        else $error("cascade skipped a level");
endmodule

bind hiz_min_pyramid_build_unit hmpb_checker u_hmpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_level_index (o_level_index),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_min_depth   (o_min_depth),
    .o_run_last    (o_run_last)
);
`default_nettype wire
